// ===== sv/tegs_pkg.sv =====
// shared types, constants and the divider step function of the timing event gateway sequencer
`timescale 1ns / 1ps

package tegs_pkg;

    // configuration port geometry
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = 3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_TRIGGER_CODE    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TRIGGER_GAP     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_UTC_GAP         = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_EVENT_SOURCE    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LATENCY_NS      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BEGIN_EXEC_CODE = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_END_EXEC_CODE   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_COMMAND_CODE    = 3'd7;

    // register reset values
    localparam logic [7:0]  TRIGGER_CODE_RESET = 8'd55;
    localparam logic [19:0] LATENCY_NS_RESET   = 20'(73575 + 50000);

    // event queue depth
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // utc conversion
    localparam int          UTC_COUNT     = 5;
    localparam logic [7:0]  UTC_BASE_CODE = 8'hE0;
    localparam logic [19:0] NS_PER_MS     = 20'd1000000;
    localparam logic [19:0] MS_PER_SEC    = 20'd1000;
    localparam logic [63:0] MS_AT_2008    = 64'd1199142000000;
    localparam int          DIV_BITS_PER_CYCLE = 8;
    localparam logic [2:0]  DIV_LAST_CYCLE = 3'(64 / DIV_BITS_PER_CYCLE - 1);

    // utc word indexes
    localparam logic [2:0] UTC_W_MSEC    = 3'd0;
    localparam logic [2:0] UTC_W_MIX     = 3'd1;
    localparam logic [2:0] UTC_W_SEC_HI  = 3'd2;
    localparam logic [2:0] UTC_W_SEC_MID = 3'd3;
    localparam logic [2:0] UTC_W_SEC_LO  = 3'd4;

    // steps of a trigger run
    localparam logic [3:0] STEP_EVENT     = 4'd0;
    localparam logic [3:0] STEP_BEGIN     = 4'd1;
    localparam logic [3:0] STEP_UTC_FIRST = 4'd2;
    localparam logic [3:0] STEP_UTC_LAST  = 4'(2 + UTC_COUNT - 1);
    localparam logic [3:0] STEP_CMD_A     = 4'(2 + UTC_COUNT);
    localparam logic [3:0] STEP_CMD_B     = 4'(3 + UTC_COUNT);
    localparam logic [3:0] STEP_END       = 4'(4 + UTC_COUNT);

    typedef struct packed {
        logic [7:0]  event_code;
        logic [15:0] telegram_in;
        logic [63:0] deadline_ns;
        logic [63:0] now_ns;
    } t_in_word;

    typedef struct packed {
        logic [15:0] telegram_out;
        logic [63:0] emit_time_ns;
        logic [7:0]  gap_setting;
        logic        gap_valid;
        logic        late;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic [7:0]  trigger_code;
        logic [7:0]  trigger_gap;
        logic [7:0]  utc_gap;
        logic [3:0]  event_source;
        logic [19:0] latency_ns;
        logic [7:0]  begin_exec_code;
        logic [7:0]  end_exec_code;
        logic [7:0]  command_code;
    } t_cfg;

    typedef struct packed {
        logic [15:0] telegram;
        logic [63:0] emit_ns;
        logic        late;
        logic        trigger;
    } t_evt_entry;

    typedef struct packed {
        logic        done;
        logic [9:0]  msec;
        logic [29:0] sec;
    } t_utc_time;

    typedef struct packed {
        logic [20:0] rem;
        logic [7:0]  quo;
    } t_div_step;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_NS,
        DIV_ADJ,
        DIV_MS
    } t_div_state;

    // eight restoring shift-subtract steps against a constant-range divisor
    function automatic t_div_step div_step8(input logic [20:0] rem_in,
                                            input logic [7:0]  bits_in,
                                            input logic [19:0] divisor);
        t_div_step   res;
        logic [20:0] r;
        logic [7:0]  q;
        r = rem_in;
        q = '0;
        for (int i = 7; i >= 0; i--) begin
            r = {r[19:0], bits_in[i]};
            if (r >= {1'b0, divisor}) begin
                r = r - {1'b0, divisor};
                q[i] = 1'b1;
            end
        end
        res.rem = r;
        res.quo = q;
        return res;
    endfunction

endpackage

// ===== sv/timing_event_gateway_sequencer.sv =====
// top level of the timing event gateway sequencer: register port, front end, queue, sequencer
`timescale 1ns / 1ps

// Timing events enter on the event channel (i_evt_valid, i_evt_data, o_evt_stall); the
// word moves at an edge with valid high and stall low. Telegrams leave on the telegram
// channel (o_tel_valid, o_tel_data, i_tel_stall), one word per telegram, the last word
// of an event marked by last.
// An ordinary event gives one word, which passes the queue, the current-event register and
// the output register; such events stream at one per cycle while the receiver does not stall.
// A trigger event gives ten words. The first two follow at one per cycle while the receiver
// does not stall; the five utc words wait for the utc converter, which runs two divisions
// with a subtract between them.
// A queue of QUEUE_DEPTH events parts the front end from the sequencer; o_evt_stall
// rises only while that queue is full.
// When the receiver stalls, the output word holds and the sequencer waits; events keep
// entering until the queue fills. Reset (i_rst_n low, synchronous) empties the queue and
// the output register and loads the register defaults. Registers sit at byte addresses
// 4*index on the APB-style port and pready is always high. The user must see that registers
// are written only while the block is idle; the block itself does not enforce this.
module timing_event_gateway_sequencer import tegs_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_evt_valid,
    input  t_in_word           i_evt_data,
    output logic               o_evt_stall,
    output logic               o_tel_valid,
    output t_out_word          o_tel_data,
    input  logic               i_tel_stall,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg                 r_cfg;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 q_full;
    logic                 q_nonempty;
    logic                 push;
    logic                 pop;
    t_evt_entry           push_entry;
    t_evt_entry           head_entry;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_code    <= TRIGGER_CODE_RESET;
            r_cfg.trigger_gap     <= '0;
            r_cfg.utc_gap         <= '0;
            r_cfg.event_source    <= '0;
            r_cfg.latency_ns      <= LATENCY_NS_RESET;
            r_cfg.begin_exec_code <= '0;
            r_cfg.end_exec_code   <= '0;
            r_cfg.command_code    <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_TRIGGER_CODE:    r_cfg.trigger_code    <= pwdata[7:0];
                REG_TRIGGER_GAP:     r_cfg.trigger_gap     <= pwdata[7:0];
                REG_UTC_GAP:         r_cfg.utc_gap         <= pwdata[7:0];
                REG_EVENT_SOURCE:    r_cfg.event_source    <= pwdata[3:0];
                REG_LATENCY_NS:      r_cfg.latency_ns      <= pwdata[19:0];
                REG_BEGIN_EXEC_CODE: r_cfg.begin_exec_code <= pwdata[7:0];
                REG_END_EXEC_CODE:   r_cfg.end_exec_code   <= pwdata[7:0];
                REG_COMMAND_CODE:    r_cfg.command_code    <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TRIGGER_CODE:    prdata = {24'd0, r_cfg.trigger_code};
            REG_TRIGGER_GAP:     prdata = {24'd0, r_cfg.trigger_gap};
            REG_UTC_GAP:         prdata = {24'd0, r_cfg.utc_gap};
            REG_EVENT_SOURCE:    prdata = {28'd0, r_cfg.event_source};
            REG_LATENCY_NS:      prdata = {12'd0, r_cfg.latency_ns};
            REG_BEGIN_EXEC_CODE: prdata = {24'd0, r_cfg.begin_exec_code};
            REG_END_EXEC_CODE:   prdata = {24'd0, r_cfg.end_exec_code};
            REG_COMMAND_CODE:    prdata = {24'd0, r_cfg.command_code};
            default:             prdata = '0;
        endcase
    end

    tegs_front u_front (
        .i_evt_valid (i_evt_valid),
        .i_evt_data  (i_evt_data),
        .o_evt_stall (o_evt_stall),
        .i_cfg       (r_cfg),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    tegs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_entry    (push_entry),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_entry    (head_entry)
    );

    tegs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_nonempty (q_nonempty),
        .i_q_entry    (head_entry),
        .o_pop        (pop),
        .o_tel_valid  (o_tel_valid),
        .o_tel_data   (o_tel_data),
        .i_tel_stall  (i_tel_stall)
    );

endmodule

// ===== sv/tegs_front.sv =====
// front end: accepts events, forms the emit time and late flag, classifies triggers
`timescale 1ns / 1ps

module tegs_front import tegs_pkg::*; (
    input  logic       i_evt_valid,
    input  t_in_word   i_evt_data,
    output logic       o_evt_stall,
    input  t_cfg       i_cfg,
    input  logic       i_q_full,
    output logic       o_push,
    output t_evt_entry o_entry
);

    logic [63:0] emit_ns;

    assign emit_ns = i_evt_data.deadline_ns + {44'd0, i_cfg.latency_ns};

    assign o_evt_stall      = i_q_full;
    assign o_push           = i_evt_valid && !i_q_full;
    assign o_entry.telegram = i_evt_data.telegram_in;
    assign o_entry.emit_ns  = emit_ns;
    assign o_entry.late     = i_evt_data.now_ns > emit_ns;
    assign o_entry.trigger  = i_evt_data.event_code == i_cfg.trigger_code;

endmodule

// ===== sv/tegs_queue.sv =====
// short event queue between the front end and the sequencer
`timescale 1ns / 1ps

module tegs_queue import tegs_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_evt_entry i_entry,
    input  logic       i_pop,
    output logic       o_full,
    output logic       o_nonempty,
    output t_evt_entry o_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_evt_entry       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_full     = r_count == CNT_W'(DEPTH);
    assign o_nonempty = r_count != '0;
    assign o_entry    = r_mem[r_rd_ptr];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("event queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("event queue popped while empty");

endmodule

// ===== sv/tegs_utc_div.sv =====
// utc converter: emit time to milliseconds and seconds since 2008, 8 quotient bits a cycle
`timescale 1ns / 1ps

module tegs_utc_div import tegs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_emit_ns,
    output t_utc_time   o_utc
);

    t_div_state  r_state, n_state;
    logic [2:0]  r_cnt, n_cnt;
    logic [20:0] r_rem, n_rem;
    logic [63:0] r_quo, n_quo;
    logic        r_done, n_done;
    t_div_step   step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    always_comb begin
        // dividend bits leave at the top while quotient bits enter at the bottom
        step    = div_step8(r_rem, r_quo[63:56], (r_state == DIV_MS) ? MS_PER_SEC : NS_PER_MS);
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_done  = r_done;
        if (i_start) begin
            n_state = DIV_NS;
            n_cnt   = '0;
            n_rem   = '0;
            n_quo   = i_emit_ns;
            n_done  = 1'b0;
        end else begin
            unique case (r_state)
                DIV_IDLE: begin
                end
                DIV_NS: begin
                    n_rem = step.rem;
                    n_quo = {r_quo[55:0], step.quo};
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == DIV_LAST_CYCLE) begin
                        n_state = DIV_ADJ;
                    end
                end
                DIV_ADJ: begin
                    // wraps when the time lies before 2008
                    n_quo   = r_quo - MS_AT_2008;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = DIV_MS;
                end
                DIV_MS: begin
                    n_rem = step.rem;
                    n_quo = {r_quo[55:0], step.quo};
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == DIV_LAST_CYCLE) begin
                        n_state = DIV_IDLE;
                        n_done  = 1'b1;
                    end
                end
                default: begin
                    n_state = DIV_IDLE;
                end
            endcase
        end
    end

    assign o_utc.done = r_done;
    assign o_utc.msec = r_rem[9:0];
    assign o_utc.sec  = r_quo[29:0];

endmodule

// ===== sv/tegs_back.sv =====
// back end: steps through the telegrams of one event into the output register
`timescale 1ns / 1ps

module tegs_back import tegs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_q_nonempty,
    input  t_evt_entry i_q_entry,
    output logic       o_pop,
    output logic       o_tel_valid,
    output t_out_word  o_tel_data,
    input  logic       i_tel_stall
);

    t_evt_entry r_cur;
    logic       r_busy, n_busy;
    logic [3:0] r_step, n_step;
    logic       r_out_valid, n_out_valid;
    t_out_word  r_out_data, n_tel;
    t_utc_time  utc;
    logic       can_load;
    logic       need_utc;
    logic       emit;
    logic       is_last;
    logic       pop;
    logic [2:0] utc_idx;
    logic [7:0] utc_data;
    logic [15:0] cmd_tel;

    tegs_utc_div u_utc_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (pop && i_q_entry.trigger),
        .i_emit_ns (i_q_entry.emit_ns),
        .o_utc     (utc)
    );

    assign can_load = !r_out_valid || !i_tel_stall;
    assign need_utc = r_cur.trigger && r_step >= STEP_UTC_FIRST && r_step <= STEP_UTC_LAST;
    assign emit     = r_busy && can_load && (!need_utc || utc.done);
    assign is_last  = !r_cur.trigger || r_step == STEP_END;
    // next event is taken in the same cycle as the last word of the current one
    assign pop      = i_q_nonempty && (!r_busy || (emit && is_last));
    assign o_pop    = pop;

    assign utc_idx = 3'(r_step - STEP_UTC_FIRST);
    assign cmd_tel = {i_cfg.event_source, 4'hF, i_cfg.command_code};

    always_comb begin
        unique case (utc_idx)
            UTC_W_MSEC:    utc_data = utc.msec[9:2];
            UTC_W_MIX:     utc_data = {utc.msec[1:0], utc.sec[29:24]};
            UTC_W_SEC_HI:  utc_data = utc.sec[23:16];
            UTC_W_SEC_MID: utc_data = utc.sec[15:8];
            UTC_W_SEC_LO:  utc_data = utc.sec[7:0];
            default:       utc_data = 8'h00;
        endcase
    end

    always_comb begin
        n_tel.telegram_out = r_cur.telegram;
        n_tel.emit_time_ns = r_cur.emit_ns;
        n_tel.gap_setting  = 8'h00;
        n_tel.gap_valid    = 1'b0;
        n_tel.late         = r_cur.late;
        n_tel.last         = 1'b1;
        if (r_cur.trigger) begin
            n_tel.gap_setting = i_cfg.trigger_gap;
            n_tel.gap_valid   = 1'b1;
            n_tel.last        = 1'b0;
            unique case (r_step) inside
                STEP_EVENT: begin
                end
                STEP_BEGIN: begin
                    n_tel.telegram_out = {r_cur.telegram[15:8], i_cfg.begin_exec_code};
                end
                [STEP_UTC_FIRST:STEP_UTC_LAST]: begin
                    n_tel.telegram_out = {utc_data, UTC_BASE_CODE + {5'd0, utc_idx}};
                    if (r_step != STEP_UTC_LAST) begin
                        n_tel.gap_setting = i_cfg.utc_gap;
                    end
                end
                STEP_CMD_A, STEP_CMD_B: begin
                    n_tel.telegram_out = cmd_tel;
                end
                STEP_END: begin
                    n_tel.telegram_out = {r_cur.telegram[15:8], i_cfg.end_exec_code};
                    n_tel.gap_setting  = 8'h00;
                    n_tel.gap_valid    = 1'b0;
                    n_tel.last         = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (pop) begin
            n_busy = 1'b1;
            n_step = STEP_EVENT;
        end else if (emit) begin
            n_busy = !is_last;
            n_step = r_step + 1'b1;
        end
        n_out_valid = emit ? 1'b1 : (r_out_valid && i_tel_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= STEP_EVENT;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cur <= i_q_entry;
        end
        if (emit) begin
            r_out_data <= n_tel;
        end
    end

    assign o_tel_valid = r_out_valid;
    assign o_tel_data  = r_out_data;

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_step <= STEP_END)
        else $error("sequence step past the end of a run");

    a_ordinary_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_cur.trigger) |-> r_step == STEP_EVENT)
        else $error("ordinary event went past its single word");

    a_utc_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(utc.done) |-> (r_busy && r_cur.trigger))
        else $error("utc conversion finished with no trigger run in progress");

endmodule

// ===== tb/tb_timing_event_gateway_sequencer.sv =====
// testbench for the timing event gateway sequencer: event stimulus, telegram prediction, checks
`timescale 1ns / 1ps

module tb_timing_event_gateway_sequencer;
    import tegs_pkg::*;

    typedef struct {
        t_in_word ev;
        bit       drain_first;
    } t_pending_evt;

    typedef enum { SET_RANDOM, SET_HIGHEST, SET_LOWEST } t_reg_setting;

    localparam int SETTLE_CYCLES = 60;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RANDOM_EVENTS_PER_PHASE = 44;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_evt_valid = 1'b0;
    t_in_word           i_evt_data  = '0;
    logic               o_evt_stall;
    logic               o_tel_valid;
    t_out_word          o_tel_data;
    logic               i_tel_stall = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [PDATA_W-1:0] pwdata      = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    t_cfg         cfg;
    t_pending_evt evt_pending[$];
    t_pending_evt next_evt;
    t_out_word    tel_expected[$];
    t_out_word    exp_word;
    logic         evt_taken = 1'b0;
    int unsigned  calm_left = 0;
    int unsigned  tx_idle_pct = 0;
    int unsigned  rx_idle_pct = 0;
    int           errors = 0;
    int           phase;

    timing_event_gateway_sequencer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (i_evt_valid),
        .i_evt_data  (i_evt_data),
        .o_evt_stall (o_evt_stall),
        .o_tel_valid (o_tel_valid),
        .o_tel_data  (o_tel_data),
        .i_tel_stall (i_tel_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cfg = '0;
        cfg.trigger_code = TRIGGER_CODE_RESET;
        cfg.latency_ns   = LATENCY_NS_RESET;
    end

    function automatic void push_telegram(input logic [15:0] tel, input logic [63:0] emit,
                                          input logic [7:0] gap, input logic gv,
                                          input logic late_flag, input logic last_flag);
        t_out_word w;
        w.telegram_out = tel;
        w.emit_time_ns = emit;
        w.gap_setting  = gap;
        w.gap_valid    = gv;
        w.late         = late_flag;
        w.last         = last_flag;
        tel_expected.push_back(w);
    endfunction

    // telegrams that one accepted event word produces under the current settings
    task automatic predict_telegrams(input t_in_word ev);
        logic [63:0] emit;
        logic [63:0] ms;
        logic [9:0]  msec;
        logic [29:0] sec;
        logic [7:0]  utc_data [5];
        logic [15:0] cmd;
        logic        late_flag;
        int          k;
        emit = ev.deadline_ns + 64'(cfg.latency_ns);
        late_flag = ev.now_ns > emit;
        if (ev.event_code != cfg.trigger_code) begin
            push_telegram(ev.telegram_in, emit, 8'd0, 1'b0, late_flag, 1'b1);
            return;
        end
        // milliseconds since 2008, wraps for earlier times
        ms   = emit / 64'(NS_PER_MS) - MS_AT_2008;
        msec = 10'(ms % 64'd1000);
        sec  = 30'(ms / 64'd1000);
        utc_data[0] = msec[9:2];
        utc_data[1] = {msec[1:0], sec[29:24]};
        utc_data[2] = sec[23:16];
        utc_data[3] = sec[15:8];
        utc_data[4] = sec[7:0];
        cmd = {cfg.event_source, 4'hF, cfg.command_code};
        push_telegram(ev.telegram_in, emit, cfg.trigger_gap, 1'b1, late_flag, 1'b0);
        push_telegram({ev.telegram_in[15:8], cfg.begin_exec_code}, emit, cfg.trigger_gap,
                      1'b1, late_flag, 1'b0);
        for (k = 0; k < UTC_COUNT; k++) begin
            push_telegram({utc_data[k], UTC_BASE_CODE + 8'(k)}, emit,
                          (k < UTC_COUNT - 1) ? cfg.utc_gap : cfg.trigger_gap,
                          1'b1, late_flag, 1'b0);
        end
        push_telegram(cmd, emit, cfg.trigger_gap, 1'b1, late_flag, 1'b0);
        push_telegram(cmd, emit, cfg.trigger_gap, 1'b1, late_flag, 1'b0);
        push_telegram({ev.telegram_in[15:8], cfg.end_exec_code}, emit, 8'd0, 1'b0,
                      late_flag, 1'b1);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            REG_TRIGGER_CODE:    cfg.trigger_code    = value[7:0];
            REG_TRIGGER_GAP:     cfg.trigger_gap     = value[7:0];
            REG_UTC_GAP:         cfg.utc_gap         = value[7:0];
            REG_EVENT_SOURCE:    cfg.event_source    = value[3:0];
            REG_LATENCY_NS:      cfg.latency_ns      = value[19:0];
            REG_BEGIN_EXEC_CODE: cfg.begin_exec_code = value[7:0];
            REG_END_EXEC_CODE:   cfg.end_exec_code   = value[7:0];
            REG_COMMAND_CODE:    cfg.command_code    = value[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_settings(input t_reg_setting mode);
        logic [REG_IDX_W-1:0] idx;
        logic [31:0]          mask;
        int                   r;
        for (r = 0; r < 8; r++) begin
            idx = REG_IDX_W'(r);
            mask = (idx == REG_EVENT_SOURCE) ? 32'hF :
                   (idx == REG_LATENCY_NS)   ? 32'hFFFFF : 32'hFF;
            case (mode)
                SET_HIGHEST: write_reg(idx, mask);
                SET_LOWEST:  write_reg(idx, 32'd0);
                default:     write_reg(idx, $urandom & mask);
            endcase
        end
    endtask

    function automatic void add_event(input logic [7:0] code, input logic [15:0] tel,
                                      input logic [63:0] deadline, input logic [63:0] now,
                                      input bit drain);
        t_pending_evt p;
        p.ev.event_code  = code;
        p.ev.telegram_in = tel;
        p.ev.deadline_ns = deadline;
        p.ev.now_ns      = now;
        p.drain_first    = drain;
        evt_pending.push_back(p);
    endfunction

    task automatic queue_directed_events();
        logic [63:0] lat;
        logic [63:0] at_2008;
        logic [63:0] dl;
        logic [7:0]  trg;
        lat     = 64'(cfg.latency_ns);
        at_2008 = MS_AT_2008 * 64'(NS_PER_MS);
        trg     = cfg.trigger_code;
        add_event(8'h00, 16'h0000, 64'd0, 64'd0, 1'b0);
        // emit time wraps past the top, now is far beyond it
        add_event(8'hFF, 16'hFFFF, '1, '1, 1'b0);
        add_event(trg - 8'd1, 16'h1234, 64'd1700000000000000000, 64'd0, 1'b0);
        // exactly at the 2008 epoch, now equal to the emit time
        add_event(trg, 16'hA537, at_2008 - lat, at_2008, 1'b0);
        // long before 2008, millisecond count wraps
        add_event(trg, 16'hFFFF, 64'd0, lat + 64'd1, 1'b0);
        add_event(trg, 16'h0000, '1, 64'd0, 1'b0);
        // wait for the block to drain before this one
        dl = 64'd1700000000123456789;
        add_event(trg, 16'h5A37, dl, '1, 1'b1);
        add_event(trg, 16'hC337, at_2008 - lat - 64'd1, at_2008 - 64'd2, 1'b0);
        add_event(trg, 16'h0F37, (MS_AT_2008 + 64'd1999) * 64'(NS_PER_MS) - lat,
                  64'd5, 1'b0);
        add_event(trg + 8'd1, 16'h8138, dl, dl + lat + 64'd1, 1'b0);
        // back-to-back mix to fill the event queue
        add_event(8'h80, 16'h7F80, dl, dl, 1'b0);
        add_event(8'h7F, 16'h807F, dl, dl + lat, 1'b0);
        add_event(trg, 16'h3C37, dl + 64'd999999, 64'd0, 1'b0);
        add_event(8'h55, 16'hAA55, 64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA, 1'b0);
        add_event(trg, 16'h6937, 64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555, 1'b0);
        add_event(8'hAA, 16'h55AA, 64'hFFFFFFFF00000000, 64'h00000000FFFFFFFF, 1'b0);
    endtask

    task automatic queue_random_event();
        logic [7:0]  code;
        logic [63:0] lat;
        logic [63:0] dl;
        logic [63:0] emit;
        logic [63:0] now;
        lat  = 64'(cfg.latency_ns);
        code = ($urandom_range(99) < 50) ? cfg.trigger_code : 8'($urandom);
        case ($urandom_range(5))
            0: dl = {$urandom, $urandom};
            1: dl = 64'd1700000000000000000 + {24'd0, 8'($urandom), $urandom};
            2: dl = {8'h00, 24'($urandom), $urandom};
            3: dl = 64'd0 - 64'($urandom_range(3000000));
            4: dl = MS_AT_2008 * 64'(NS_PER_MS) - lat + 64'($urandom_range(4000000))
                    - 64'd2000000;
            default: dl = ({$urandom, $urandom} / 64'(NS_PER_MS)) * 64'(NS_PER_MS) - lat
                          + 64'($urandom_range(2)) - 64'd1;
        endcase
        emit = dl + lat;
        case ($urandom_range(4))
            0: now = emit;
            1: now = emit + 64'd1;
            2: now = emit - 64'd1;
            default: now = {$urandom, $urandom};
        endcase
        add_event(code, 16'($urandom), dl, now, $urandom_range(99) < 3);
    endtask

    // wait until every event word went in and every telegram came out, then settle
    task automatic wait_drained();
        int cycles;
        cycles = 0;
        while ((evt_pending.size() != 0 || i_evt_valid || tel_expected.size() != 0)
               && cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // event driver: valid is decided without looking at stall, payload held until taken
    always @(negedge i_clk) begin
        if (calm_left != 0) begin
            calm_left <= calm_left - 1;
        end else if ($urandom_range(99) < 3) begin
            calm_left <= $urandom_range(60, 20);
        end
        if (!i_rst_n) begin
            i_evt_valid <= 1'b0;
        end else if (!i_evt_valid || evt_taken) begin
            if (evt_pending.size() != 0 &&
                !(evt_pending[0].drain_first && tel_expected.size() != 0) &&
                (calm_left != 0 || $urandom_range(99) >= tx_idle_pct)) begin
                next_evt = evt_pending.pop_front();
                i_evt_valid <= 1'b1;
                i_evt_data  <= next_evt.ev;
            end else begin
                i_evt_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_tel_stall <= (calm_left == 0) && ($urandom_range(99) < rx_idle_pct);
    end

    // monitor: accepted event words feed the predictor, accepted telegrams are checked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            evt_taken <= 1'b0;
        end else begin
            evt_taken <= i_evt_valid && !o_evt_stall;
            if (i_evt_valid && !o_evt_stall) begin
                predict_telegrams(i_evt_data);
            end
            if (o_tel_valid && !i_tel_stall) begin
                if (tel_expected.size() == 0) begin
                    $display("%0t: telegram word %h arrived with nothing expected",
                             $time, o_tel_data);
                    errors++;
                end else begin
                    exp_word = tel_expected.pop_front();
                    if (o_tel_data !== exp_word) begin
                        $display("%0t: expected tel=%h emit=%h gap=%h gv=%b late=%b last=%b",
                                 $time, exp_word.telegram_out, exp_word.emit_time_ns,
                                 exp_word.gap_setting, exp_word.gap_valid, exp_word.late,
                                 exp_word.last);
                        $display("%0t: actual   tel=%h emit=%h gap=%h gv=%b late=%b last=%b",
                                 $time, o_tel_data.telegram_out, o_tel_data.emit_time_ns,
                                 o_tel_data.gap_setting, o_tel_data.gap_valid,
                                 o_tel_data.late, o_tel_data.last);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct = 17;
        rx_idle_pct = 56;
        queue_directed_events();
        wait_drained();
        for (phase = 1; phase <= 6; phase++) begin
            if (phase == 3) begin
                tx_idle_pct = 56;
                rx_idle_pct = 17;
            end
            if (phase == 5) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (phase)
                2:       load_settings(SET_HIGHEST);
                3:       load_settings(SET_LOWEST);
                default: load_settings(SET_RANDOM);
            endcase
            repeat (RANDOM_EVENTS_PER_PHASE) queue_random_event();
            wait_drained();
        end
        if (tel_expected.size() != 0 || evt_pending.size() != 0) begin
            $display("%0t: %0d telegram words never arrived, %0d event words not taken",
                     $time, tel_expected.size(), evt_pending.size());
        end
        if (errors == 0 && tel_expected.size() == 0 && evt_pending.size() == 0) begin
            $display("[timing_event_gateway_sequencer] OK");
        end else begin
            $display("[timing_event_gateway_sequencer] ERROR");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("%0t: run timed out", $time);
        $display("[timing_event_gateway_sequencer] ERROR");
        $finish;
    end

endmodule
